>>> hdl/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants, operand classes and helpers for the inverse square root
// pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] MAGIC         = 32'h5f3759df;
  localparam logic [31:0] ONE_HALF      = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES  = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN     = 32'h7fc00000;
  localparam logic [7:0]  EXP_MAX       = 8'hff;

  // class of an operation result before packing
  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_INF,
    KIND_NAN
  } fisr_kind_t;

  // leading zero count, 48 when the word is all zeros
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

>>> hdl/fisr_value_if.sv
// ----------------------------------------------------------------------------
// fisr_value_if
// Input stream channel carrying one binary32 operand per transaction.
// ----------------------------------------------------------------------------
interface fisr_value_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

>>> hdl/fisr_estimate_if.sv
// ----------------------------------------------------------------------------
// fisr_estimate_if
// Output stream channel carrying one binary32 estimate per transaction.
// ----------------------------------------------------------------------------
interface fisr_estimate_if;
  logic        valid;
  logic        ready;
  logic [31:0] estimate_bits;

  modport source (output valid, output estimate_bits, input ready);
  modport sink (input valid, input estimate_bits, output ready);
endinterface

>>> hdl/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul
// Three stage binary32 multiplier, round to nearest even, full subnormal
// support, with a side word carried alongside.
// ----------------------------------------------------------------------------
module fisr_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] aux_in,
  output logic        vout,
  output logic [31:0] z,
  output logic [31:0] aux_out
);
  import fisr_pkg::*;

  // stage 1: unpack and multiply
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  fisr_kind_t  kind_next;

  logic        v1, sign1;
  fisr_kind_t  kind1;
  logic [47:0] prod1;
  logic [8:0]  esum1;
  logic [31:0] aux1;

  always_comb begin
    a_nan  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_nan  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    priority if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
      kind_next = KIND_NAN;
    end else if (a_inf || b_inf) begin
      kind_next = KIND_INF;
    end else if (a_zero || b_zero) begin
      kind_next = KIND_ZERO;
    end else begin
      kind_next = KIND_NUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign1 <= a[31] ^ b[31];
      kind1 <= kind_next;
      prod1 <= ma * mb;
      esum1 <= {1'b0, ea} + {1'b0, eb};
      aux1  <= aux_in;
    end
  end

  // stage 2: normalize left
  logic [5:0]         lz;
  logic               v2, sign2;
  fisr_kind_t         kind2;
  logic [47:0]        pn2;
  logic signed [10:0] be2;
  logic [31:0]        aux2;

  assign lz = lzc48(prod1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign2 <= sign1;
      kind2 <= kind1;
      pn2   <= prod1 << lz;
      be2   <= $signed({2'b00, esum1}) - 11'sd126 - $signed({5'b00000, lz});
      aux2  <= aux1;
    end
  end

  // stage 3: denormalize, round and pack
  logic [7:0]  sh, expf;
  logic [47:0] shifted;
  logic        lost, guard, sticky, inc;
  logic [30:0] packed_mag;
  logic [31:0] z_next;
  logic        ovf;
  logic signed [10:0] sh_wide;

  always_comb begin
    ovf     = (be2 >= 11'sd255);
    sh_wide = 11'sd1 - be2;
    if (be2 > 11'sd0) begin
      sh   = 8'd0;
      expf = be2[7:0];
    end else begin
      sh   = sh_wide[7:0];
      expf = 8'd0;
    end
    shifted    = pn2 >> sh;
    lost       = |(pn2 & ~({48{1'b1}} << sh));
    guard      = shifted[23];
    sticky     = (|shifted[22:0]) | lost;
    inc        = guard & (sticky | shifted[24]);
    packed_mag = {expf, shifted[46:24]} + {30'd0, inc};
    unique case (kind2)
      KIND_NAN:  z_next = CANON_NAN;
      KIND_INF:  z_next = {sign2, EXP_MAX, 23'd0};
      KIND_ZERO: z_next = {sign2, 31'd0};
      default:   z_next = ovf ? {sign2, EXP_MAX, 23'd0} : {sign2, packed_mag};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z       <= z_next;
      aux_out <= aux2;
    end
  end

endmodule

>>> hdl/fisr_fadd.sv
// ----------------------------------------------------------------------------
// fisr_fadd
// Three stage binary32 adder, round to nearest even, full subnormal support,
// with a side word carried alongside.
// ----------------------------------------------------------------------------
module fisr_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] aux_in,
  output logic        vout,
  output logic [31:0] z,
  output logic [31:0] aux_out
);
  import fisr_pkg::*;

  // stage 1: unpack, order by magnitude, align
  logic        a_nan, a_inf, b_nan, b_inf, swap;
  logic [31:0] big, lesser;
  logic [7:0]  eb_big, eb_small, dexp;
  logic [26:0] ext_small, sh_small;
  logic        lost;
  fisr_kind_t  kind_next;
  logic        sign_next;

  logic        v1, sign1, sub1;
  fisr_kind_t  kind1;
  logic [7:0]  e1;
  logic [26:0] ma1, mb1;
  logic [31:0] aux1;

  always_comb begin
    a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
    a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    swap  = b[30:0] > a[30:0];
    big    = swap ? b : a;
    lesser = swap ? a : b;
    eb_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb_small = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
    dexp      = eb_big - eb_small;
    ext_small = {lesser[30:23] != 8'd0, lesser[22:0], 3'b000};
    sh_small  = ext_small >> dexp;
    lost      = |(ext_small & ~({27{1'b1}} << dexp));
    sign_next = big[31];
    priority if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      kind_next = KIND_NAN;
    end else if (a_inf || b_inf) begin
      kind_next = KIND_INF;
      sign_next = a_inf ? a[31] : b[31];
    end else begin
      kind_next = KIND_NUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign1 <= sign_next;
      sub1  <= a[31] ^ b[31];
      kind1 <= kind_next;
      e1    <= eb_big;
      ma1   <= {big[30:23] != 8'd0, big[22:0], 3'b000};
      mb1   <= {sh_small[26:1], sh_small[0] | lost};
      aux1  <= aux_in;
    end
  end

  // stage 2: add or subtract, normalize left
  logic [27:0] sum;
  logic [5:0]  lz;
  logic [7:0]  shl;

  logic        v2, sign2;
  fisr_kind_t  kind2;
  logic [27:0] sn2;
  logic [8:0]  be2;
  logic [31:0] aux2;

  always_comb begin
    sum = sub1 ? ({1'b0, ma1} - {1'b0, mb1}) : ({1'b0, ma1} + {1'b0, mb1});
    lz  = lzc48({sum, 20'd0});
    shl = ({2'b00, lz} > e1) ? e1 : {2'b00, lz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // exact cancellation gives +0
      sign2 <= (kind1 == KIND_NUM && sub1 && sum == 28'd0) ? 1'b0 : sign1;
      kind2 <= kind1;
      sn2   <= sum << shl;
      be2   <= {1'b0, e1} + 9'd1 - {1'b0, shl};
      aux2  <= aux1;
    end
  end

  // stage 3: round and pack
  logic [7:0]  expf;
  logic        guard, sticky, inc;
  logic [30:0] packed_mag;
  logic [31:0] z_next;

  always_comb begin
    expf       = sn2[27] ? be2[7:0] : 8'd0;
    guard      = sn2[3];
    sticky     = |sn2[2:0];
    inc        = guard & (sticky | sn2[4]);
    packed_mag = {expf, sn2[26:4]} + {30'd0, inc};
    unique case (kind2)
      KIND_NAN: z_next = CANON_NAN;
      KIND_INF: z_next = {sign2, EXP_MAX, 23'd0};
      default:  z_next = (be2 >= 9'd255) ? {sign2, EXP_MAX, 23'd0}
                                         : {sign2, packed_mag};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z       <= z_next;
      aux_out <= aux2;
    end
  end

endmodule

>>> hdl/fast_inverse_square_root_unit.sv
// five 3-stage float units lie between operand transaction and result
// throughput: one operand per cycle unless stalled (fully pipelined units)
// a stalled result holds the whole pipeline; nothing is dropped or repeated
// reset clears every stage valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
// fast_inverse_square_root_unit
// Bit-guess plus one Newton step reciprocal square root on binary32.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_unit (
  input  logic clk,
  input  logic rst,
  fisr_value_if.sink      operand,
  fisr_estimate_if.source result
);
  import fisr_pkg::*;

  logic        adv;
  logic [31:0] guess;
  logic        v_half, v_t1, v_t2, v_d, v_r;
  logic [31:0] half, t1, t2, d, r;
  logic [31:0] y_half, y_t1, y_t2, y_d;

  // pipeline moves whenever the output slot is free or being emptied
  assign adv           = !result.valid || result.ready;
  assign operand.ready = adv;

  assign guess = MAGIC - {operand.value_bits[31], operand.value_bits[31:1]};

  fisr_fmul u_half (
    .clk, .rst, .en(adv), .vin(operand.valid),
    .a(operand.value_bits), .b(ONE_HALF), .aux_in(guess),
    .vout(v_half), .z(half), .aux_out(y_half)
  );

  fisr_fmul u_t1 (
    .clk, .rst, .en(adv), .vin(v_half),
    .a(half), .b(y_half), .aux_in(y_half),
    .vout(v_t1), .z(t1), .aux_out(y_t1)
  );

  fisr_fmul u_t2 (
    .clk, .rst, .en(adv), .vin(v_t1),
    .a(t1), .b(y_t1), .aux_in(y_t1),
    .vout(v_t2), .z(t2), .aux_out(y_t2)
  );

  // 1.5 - t2
  fisr_fadd u_diff (
    .clk, .rst, .en(adv), .vin(v_t2),
    .a(THREE_HALVES), .b({~t2[31], t2[30:0]}), .aux_in(y_t2),
    .vout(v_d), .z(d), .aux_out(y_d)
  );

  fisr_fmul u_step (
    .clk, .rst, .en(adv), .vin(v_d),
    .a(y_d), .b(d), .aux_in(y_d),
    .vout(v_r), .z(r), .aux_out()
  );

  assign result.valid         = v_r;
  assign result.estimate_bits = r;

endmodule

>>> hdl/fisr_checker.sv
// ----------------------------------------------------------------------------
// fisr_checker
// Port level checks for the inverse square root unit, bound to the top level.
// ----------------------------------------------------------------------------
module fisr_checker (
  input logic        clk,
  input logic        rst,
  input logic        op_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_bits
);
  import fisr_pkg::*;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a waiting result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_bits))
    else $error("stalled result changed");

  // every NaN leaves in canonical form
  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_bits[30:23] == EXP_MAX) && (res_bits[22:0] != 23'd0)
      |-> res_bits == CANON_NAN)
    else $error("non-canonical NaN on result");

  // input side is back-pressured only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    op_ready == (!res_valid || res_ready))
    else $error("operand ready does not track result stall");

endmodule

bind fast_inverse_square_root_unit fisr_checker u_fisr_checker (
  .clk(clk),
  .rst(rst),
  .op_ready(operand.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_bits(result.estimate_bits)
);

>>> sim/fast_inverse_square_root_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root_unit_test
// Streams binary32 operands through the reciprocal square root pipeline and
// compares every estimate against a bit-exact integer model of the bit guess
// and the single Newton step, under several patterns of source and sink stalls.
// ----------------------------------------------------------------------------
module fast_inverse_square_root_unit_test;
  import fisr_pkg::*;

  localparam int RANDOM_PER_PHASE = 163;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct {
    logic [31:0] operand;
    bit          known;
    logic [31:0] estimate;
  } vector_t;

  logic clk;
  logic rst;

  fisr_value_if    operand_ch ();
  fisr_estimate_if result_ch ();

  fast_inverse_square_root_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (operand_ch),
    .result  (result_ch)
  );

  logic [31:0] estimate_q [$];
  bit          known_q [$];
  logic [31:0] known_val_q [$];
  int          error_count;
  int          operand_count;
  int          estimate_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- binary32 arithmetic, round to nearest even ----------------

  function automatic bit is_nan(input logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(input logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] == 0;
  endfunction

  // value = mant * 2^expo
  function automatic void unpack(input logic [31:0] a, output logic [127:0] mant,
                                 output int expo);
    if (a[30:23] == 0) begin
      mant = 128'(a[22:0]);
      expo = -149;
    end else begin
      mant = 128'({1'b1, a[22:0]});
      expo = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] round_pack(input bit sgn, input int expo,
                                             input logic [127:0] m);
    int          p;
    int          s;
    int          field;
    logic [127:0] kept;
    bit          half;
    bit          sticky;
    if (m == 0) return {sgn, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    s = p - 23;
    if (-149 - expo > s) s = -149 - expo;
    if (s > 0) begin
      kept = m >> s;
      half = ((m >> (s - 1)) & 128'd1) != 0;
      sticky = (m & ((128'd1 << (s - 1)) - 128'd1)) != 0;
      if (half && (sticky || kept[0])) kept = kept + 1;
    end else begin
      kept = m << (-s);
    end
    if (kept[24]) begin
      kept = kept >> 1;
      s++;
    end
    if (kept == 0) return {sgn, 31'b0};
    field = kept[23] ? s + expo + 150 : 0;
    if (field >= 255) return {sgn, 8'hff, 23'b0};
    return {sgn, field[7:0], kept[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    bit           sgn;
    logic [127:0] ma;
    logic [127:0] mb;
    int           ea;
    int           eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
      return {sgn, 8'hff, 23'b0};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'b0};
    unpack(a, ma, ea);
    unpack(b, mb, eb);
    return round_pack(sgn, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mbig;
    logic [127:0] msml;
    int           ea;
    int           eb;
    int           d;
    int           ls;
    int           rs;
    int           ebig;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    unpack(a, ma, ea);
    unpack(b, mb, eb);
    // align; a far smaller operand collapses into a sticky bit
    if (ea >= eb) begin
      mbig = ma; msml = mb; ebig = ea; d = ea - eb;
    end else begin
      mbig = mb; msml = ma; ebig = eb; d = eb - ea;
    end
    ls = (d < 60) ? d : 60;
    rs = d - ls;
    mbig = mbig << ls;
    if (rs > 0)
      msml = (msml >> rs) | 128'((msml & ((128'd1 << rs) - 128'd1)) != 0);
    if (ea >= eb) begin
      ma = mbig; mb = msml;
    end else begin
      ma = msml; mb = mbig;
    end
    ebig = ebig - ls;
    if (a[31] == b[31]) return round_pack(a[31], ebig, ma + mb);
    if (ma == mb) return 32'h0;
    if (ma > mb) return round_pack(a[31], ebig, ma - mb);
    return round_pack(b[31], ebig, mb - ma);
  endfunction

  function automatic logic [31:0] rsqrt_estimate(input logic [31:0] x);
    logic [31:0] half;
    logic [31:0] guess;
    logic [31:0] t;
    logic [31:0] r;
    half  = fp_mul(x, ONE_HALF);
    guess = MAGIC - {x[31], x[31:1]};
    t = fp_mul(half, guess);
    t = fp_mul(t, guess);
    t = fp_add(THREE_HALVES, {~t[31], t[30:0]});
    r = fp_mul(guess, t);
    if (is_nan(r)) r = CANON_NAN;
    return r;
  endfunction

  // ---------------- monitors ----------------

  always @(posedge clk) begin
    if (!rst) begin
      if (operand_ch.valid && operand_ch.ready) begin
        operand_count++;
        if (known_q.pop_front())
          estimate_q.push_back(known_val_q.pop_front());
        else begin
          void'(known_val_q.pop_front());
          estimate_q.push_back(rsqrt_estimate(operand_ch.value_bits));
        end
      end
      if (result_ch.valid && result_ch.ready) begin
        estimate_count++;
        if (estimate_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected estimate_bits %h", $time, result_ch.estimate_bits);
        end else begin
          logic [31:0] want;
          want = estimate_q.pop_front();
          if (result_ch.estimate_bits !== want) begin
            error_count++;
            $display("%0t: estimate_bits expected %h actual %h", $time, want,
                     result_ch.estimate_bits);
          end
        end
      end
      if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("fast_inverse_square_root_unit_test: errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------- stimulus ----------------

  task automatic send_operand(input logic [31:0] v, input bit known, input logic [31:0] est);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_ch.valid = 1'b0;
      @(negedge clk);
    end
    known_q.push_back(known);
    known_val_q.push_back(est);
    operand_ch.valid = 1'b1;
    operand_ch.value_bits = v;
    do @(posedge clk); while (!operand_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [7:0] ex;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: ex = 8'($urandom_range(100, 154));
      5: return $urandom;
      6: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
      7: return {1'($urandom), 8'h00, 23'($urandom_range(0, 1) ? $urandom : 0)};
      8: return {1'($urandom), 8'hff, 23'($urandom_range(0, 1) ? $urandom : 0)};
      default: return {1'b1, 8'($urandom_range(1, 254)), 23'($urandom)};
    endcase
    return {1'b0, ex, 23'($urandom)};
  endfunction

  vector_t directed [] = '{
    '{32'h00000000, 0, 32'h0},          // +0
    '{32'h80000000, 0, 32'h0},          // -0, sign survives the shift
    '{32'h7f800000, 1, 32'hff800000},   // +inf
    '{32'hff800000, 1, 32'h7f800000},   // -inf
    '{32'h7fc00000, 1, CANON_NAN},
    '{32'hffffffff, 1, CANON_NAN},      // negative nan with full payload
    '{32'h7f800001, 1, CANON_NAN},      // signaling nan
    '{32'h3f800000, 0, 32'h0},
    '{32'h40800000, 0, 32'h0},
    '{32'h3e800000, 0, 32'h0},
    '{32'h40000000, 0, 32'h0},
    '{32'h3f7fffff, 0, 32'h0},
    '{32'h00000001, 0, 32'h0},          // smallest subnormal
    '{32'h007fffff, 0, 32'h0},          // largest subnormal
    '{32'h00800000, 0, 32'h0},
    '{32'h7f7fffff, 0, 32'h0},
    '{32'hbf800000, 0, 32'h0},
    '{32'h80000001, 0, 32'h0},
    '{32'h5f3759df, 0, 32'h0},
    '{32'haaaaaaaa, 0, 32'h0},
    '{32'h55555555, 0, 32'h0}
  };

  int idle_pct_by_phase  [4] = '{0, 83, 0, 9};
  int stall_pct_by_phase [4] = '{0, 0, 83, 9};

  initial begin
    rst = 1'b1;
    operand_ch.valid = 1'b0;
    operand_ch.value_bits = 32'h0;
    result_ch.ready = 1'b0;
    error_count = 0;
    operand_count = 0;
    estimate_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_pct_by_phase[ph];
      recv_stall_pct = stall_pct_by_phase[ph];
      if (ph == 0)
        foreach (directed[i])
          send_operand(directed[i].operand, directed[i].known, directed[i].estimate);
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_operand(random_operand(), 1'b0, 32'h0);
    end
    operand_ch.valid = 1'b0;

    while (estimate_q.size() != 0 || known_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operands and %0d estimates: signed zeros, infinities, nans,",
             operand_count, estimate_count);
    $display("subnormals, extremes and random binary32 under four stall patterns");
    if (error_count == 0)
      $display("fast_inverse_square_root_unit_test: clean");
    else
      $display("fast_inverse_square_root_unit_test: errors");
    $finish;
  end

endmodule
